[design/huffman_table_decoder_core_assert.svh]
// Assertion macros for the Huffman table decoder.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef HUFFMAN_TABLE_DECODER_CORE_ASSERT_SVH
`define HUFFMAN_TABLE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HUFD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HUFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/hufd_pkg.sv]
// Shared types and constants of the Huffman table decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package hufd_pkg;

	localparam int CODE_W       = 32;
	localparam int LEN_W        = 6;
	localparam int SYM_W        = 8;
	localparam int BYTE_W       = 8;
	localparam int BUF_BITS     = 40;
	localparam int BUF_CNT_W    = 6;
	localparam int COUNT_W      = 24;
	localparam int MAX_CODE_LEN = 32;
	localparam int MAX_RESULTS  = 8;
	localparam int RES_CNT_W    = 4;

	localparam int IN_TDATA_W  = 56;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 8;
	localparam int OUT_TUSER_W = 2;

	// Largest code length that the table accepts.
	localparam logic [LEN_W-1:0] LEN_LIMIT =
		(MAX_CODE_LEN < CODE_W) ? LEN_W'(MAX_CODE_LEN) : LEN_W'(CODE_W);

	localparam logic [IN_TUSER_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [IN_TUSER_W-1:0] OP_BYTE    = 2'd1;
	localparam logic [IN_TUSER_W-1:0] OP_RESTART = 2'd2;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
		logic [SYM_W-1:0]  sym;
	} entry_t;

	typedef struct packed {
		logic hit;
		logic pend;
	} match_t;

endpackage

`default_nettype wire

[design/huffman_table_decoder_core.sv]
// Huffman table decoder top level: command decode, search sequencer, result staging.
// Depends on hufd_pkg, hufd_table, hufd_match and the assertion macro header.
//
// Usage. Items arrive on the s_ stream; s_tuser carries the opcode. A load
// transfer appends one (code, length, symbol) entry to the code table, a data
// transfer appends one compressed byte to a 40-bit bit buffer, and a restart
// transfer clears the table, the stream, the counts and the sticky error.
// Decoded symbols leave on the m_ stream, with m_tlast marking the final
// result caused by one input transfer. symbol_count is written through
// cfg_we/cfg_wdata by the user, only while the block is idle; the block does not enforce this.
//
// Timing. s_tready is high only while the sequencer is idle. Valid loads,
// restarts and ignored items complete in the idle state. Each symbol search
// walks the loaded table one entry per cycle through the single compare unit
// and the table's one read port, and one data byte yields up to eight searches.
// An error ends the item with a single error result.
//
// Reset clears all control state; table contents stay undefined until loaded.
// A stalled receiver holds the output register, and the sequencer waits in
// place with one further result staged behind it until the transfer is made.
`default_nettype none

module huffman_table_decoder_core #(
	parameter int MAX_SYMBOLS = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [31:0] entry_code, [37:32] entry_length, [45:38] entry_symbol,
	// [53:46] data_byte, [55:54] zero
	input  logic [hufd_pkg::IN_TDATA_W-1:0]   s_tdata,
	// [1:0] opcode
	input  logic [hufd_pkg::IN_TUSER_W-1:0]   s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [7:0] symbol
	output logic [hufd_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// [0] done_res, [1] error
	output logic [hufd_pkg::OUT_TUSER_W-1:0]  m_tuser,
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [hufd_pkg::COUNT_W-1:0]      cfg_wdata
);
	import hufd_pkg::*;

	`include "huffman_table_decoder_core_assert.svh"

	localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int CW = $clog2(MAX_SYMBOLS + 1);
	localparam logic [CW-1:0] TABLE_FULL = CW'(MAX_SYMBOLS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_ADV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             done;
		logic             err;
	} res_t;

	localparam res_t ERR_RES = '{sym: '0, done: 1'b0, err: 1'b1};

	logic [1:0]           state_q;
	logic [COUNT_W-1:0]   sym_cnt_q;
	logic [COUNT_W-1:0]   dec_q;
	logic [CW-1:0]        entry_cnt_q;
	logic [CW-1:0]        idx_q;
	logic                 chk_s1;
	logic [BUF_BITS-1:0]  bitbuf_q;
	logic [BUF_CNT_W-1:0] nbits_q;
	logic                 err_q;
	logic [LEN_W-1:0]     best_len_q;
	logic [SYM_W-1:0]     best_sym_q;
	logic                 pend_q;
	logic [RES_CNT_W-1:0] nres_q;
	res_t                 hold_q;
	logic                 hold_v_q;
	logic                 m_tvalid_q;
	res_t                 m_res_q;
	logic                 m_last_q;

	// Input fields.
	logic [IN_TUSER_W-1:0] op;
	logic [CODE_W-1:0]     in_code;
	logic [LEN_W-1:0]      in_len;
	logic [SYM_W-1:0]      in_sym;
	logic [BYTE_W-1:0]     in_byte;
	logic                  len_bad;

	logic                  tbl_we;
	logic                  tbl_re;
	entry_t                wentry;
	entry_t                rentry;
	match_t                mres;

	logic [COUNT_W-1:0]    dec_inc;
	logic [RES_CNT_W-1:0]  nres_inc;
	logic [BUF_CNT_W-1:0]  nbits_left;
	logic                  out_free;
	logic                  out_push;
	logic                  accept;

	assign op      = s_tuser;
	assign in_code = s_tdata[31:0];
	assign in_len  = s_tdata[37:32];
	assign in_sym  = s_tdata[45:38];
	assign in_byte = s_tdata[53:46];
	assign len_bad = (in_len == '0) || (in_len > LEN_LIMIT);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// The sequencer loads the output register this cycle: a staged result
	// pushed ahead of a new one, or the final result of the item.
	assign out_push = ((state_q == ST_ADV) && !pend_q && hold_v_q && out_free)
		|| ((state_q == ST_FIN) && out_free);

	assign dec_inc    = dec_q + COUNT_W'(1);
	assign nres_inc   = nres_q + RES_CNT_W'(1);
	assign nbits_left = nbits_q - best_len_q;

	// Table write: code bits above the length are dropped before storing.
	assign tbl_we      = accept && (op == OP_LOAD) && !len_bad && (entry_cnt_q != TABLE_FULL);
	assign wentry.code = in_code & ~({CODE_W{1'b1}} << in_len);
	assign wentry.len  = in_len;
	assign wentry.sym  = in_sym;

	// The scan issues one read per cycle until every loaded entry is requested.
	assign tbl_re = (state_q == ST_SCAN) && (idx_q != entry_cnt_q);

	hufd_table #(
		.DEPTH (MAX_SYMBOLS),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (entry_cnt_q[AW-1:0]),
		.wdata (wentry),
		.re    (tbl_re),
		.raddr (idx_q[AW-1:0]),
		.rdata (rentry)
	);

	hufd_match u_match (
		.bits  (bitbuf_q),
		.nbits (nbits_q),
		.ent   (rentry),
		.res   (mres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sym_cnt_q   <= '0;
			dec_q       <= '0;
			entry_cnt_q <= '0;
			idx_q       <= '0;
			chk_s1      <= 1'b0;
			bitbuf_q    <= '0;
			nbits_q     <= '0;
			err_q       <= 1'b0;
			best_len_q  <= '0;
			best_sym_q  <= '0;
			pend_q      <= 1'b0;
			nres_q      <= '0;
			hold_q      <= '0;
			hold_v_q    <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_res_q     <= '0;
			m_last_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				sym_cnt_q <= cfg_wdata;
			end
			if (m_tvalid_q && m_tready && !out_push) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						case (op)
							OP_LOAD: begin
								if (len_bad) begin
									err_q    <= 1'b1;
									hold_q   <= ERR_RES;
									hold_v_q <= 1'b1;
									state_q  <= ST_FIN;
								end else if (entry_cnt_q != TABLE_FULL) begin
									entry_cnt_q <= entry_cnt_q + CW'(1);
								end
							end
							OP_BYTE: begin
								if (err_q) begin
									// Stuck: every byte answers with an error.
									hold_q   <= ERR_RES;
									hold_v_q <= 1'b1;
									state_q  <= ST_FIN;
								end else if (dec_q >= sym_cnt_q) begin
									// All symbols decoded; the byte is dropped.
								end else if (nbits_q > BUF_CNT_W'(BUF_BITS - BYTE_W)) begin
									err_q    <= 1'b1;
									hold_q   <= ERR_RES;
									hold_v_q <= 1'b1;
									state_q  <= ST_FIN;
								end else begin
									bitbuf_q   <= {bitbuf_q[BUF_BITS-BYTE_W-1:0], in_byte};
									nbits_q    <= nbits_q + BUF_CNT_W'(BYTE_W);
									nres_q     <= '0;
									idx_q      <= '0;
									chk_s1     <= 1'b0;
									best_len_q <= '0;
									best_sym_q <= '0;
									pend_q     <= 1'b0;
									state_q    <= ST_SCAN;
								end
							end
							OP_RESTART: begin
								entry_cnt_q <= '0;
								bitbuf_q    <= '0;
								nbits_q     <= '0;
								dec_q       <= '0;
								err_q       <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end

				ST_SCAN: begin
					// Read data for the entry requested last cycle is checked now.
					// A strictly longer match wins, so the first loaded of equals stays.
					if (chk_s1 && mres.hit && (rentry.len > best_len_q)) begin
						best_len_q <= rentry.len;
						best_sym_q <= rentry.sym;
					end
					if (chk_s1 && mres.pend) begin
						pend_q <= 1'b1;
					end
					if (tbl_re) begin
						idx_q <= idx_q + CW'(1);
					end
					chk_s1 <= tbl_re;
					if ((idx_q == entry_cnt_q) && !chk_s1) begin
						state_q <= ST_ADV;
					end
				end

				ST_ADV: begin
					if (pend_q) begin
						// Undecided prefix: wait for the next byte.
						state_q <= hold_v_q ? ST_FIN : ST_IDLE;
					end else if (!hold_v_q || out_free) begin
						if (hold_v_q) begin
							// A further result follows, so the staged one is not last.
							m_tvalid_q <= 1'b1;
							m_res_q    <= hold_q;
							m_last_q   <= 1'b0;
						end
						hold_v_q <= 1'b1;
						if (best_len_q == '0) begin
							err_q   <= 1'b1;
							hold_q  <= ERR_RES;
							state_q <= ST_FIN;
						end else begin
							hold_q.sym  <= best_sym_q;
							hold_q.done <= (dec_inc >= sym_cnt_q);
							hold_q.err  <= 1'b0;
							nbits_q     <= nbits_left;
							bitbuf_q    <= bitbuf_q & ~({BUF_BITS{1'b1}} << nbits_left);
							dec_q       <= dec_inc;
							nres_q      <= nres_inc;
							if ((nres_inc < RES_CNT_W'(MAX_RESULTS)) && (dec_inc < sym_cnt_q)) begin
								idx_q      <= '0;
								chk_s1     <= 1'b0;
								best_len_q <= '0;
								best_sym_q <= '0;
								pend_q     <= 1'b0;
								state_q    <= ST_SCAN;
							end else begin
								state_q <= ST_FIN;
							end
						end
					end
				end

				ST_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_res_q    <= hold_q;
						m_last_q   <= 1'b1;
						hold_v_q   <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_res_q.sym;
	assign m_tuser[0] = m_res_q.done;
	assign m_tuser[1] = m_res_q.err;
	assign m_tlast    = m_last_q;

	`HUFD_ASSERT_IMP(a_idle_no_staged, clk, arst_n, state_q == ST_IDLE, !hold_v_q,
		"idle with a result still staged")
	`HUFD_ASSERT_IMP(a_fin_has_staged, clk, arst_n, state_q == ST_FIN, hold_v_q,
		"final push without a staged result")
	`HUFD_ASSERT_IMP(a_scan_bound, clk, arst_n, state_q == ST_SCAN, idx_q <= entry_cnt_q,
		"scan index ran past the loaded entries")
	`HUFD_ASSERT_IMP(a_err_payload, clk, arst_n, m_tvalid && m_tuser[1],
		(m_tdata == '0) && !m_tuser[0], "error result carries a symbol or done flag")
	`HUFD_ASSERT_NEXT(a_restart_clears, clk, arst_n, accept && (op == OP_RESTART),
		(entry_cnt_q == '0) && (nbits_q == '0) && !err_q, "restart did not clear state")

endmodule

`default_nettype wire

[design/hufd_table.sv]
// Code table storage: one write port, one registered read port.
// Depends on hufd_pkg for the entry type.
`default_nettype none

module hufd_table #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  hufd_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output hufd_pkg::entry_t rdata
);
	import hufd_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[design/hufd_match.sv]
// Shared compare unit: checks one table entry against the buffered bits.
// Depends on hufd_pkg for the entry and match result types.
`default_nettype none

module hufd_match (
	input  logic [hufd_pkg::BUF_BITS-1:0]  bits,
	input  logic [hufd_pkg::BUF_CNT_W-1:0] nbits,
	input  hufd_pkg::entry_t               ent,
	output hufd_pkg::match_t               res
);
	import hufd_pkg::*;

	always_comb begin
		logic [BUF_CNT_W-1:0] sh;
		logic [BUF_BITS-1:0]  shifted;
		logic [CODE_W-1:0]    mask;
		logic [CODE_W-1:0]    lead;
		logic [CODE_W-1:0]    tail;
		mask    = ~({CODE_W{1'b1}} << ent.len);
		sh      = '0;
		shifted = '0;
		lead    = '0;
		tail    = '0;
		res     = '0;
		if (ent.len <= nbits) begin
			// The whole code fits: compare it with the leading buffered bits.
			sh      = nbits - ent.len;
			shifted = bits >> sh;
			lead    = shifted[CODE_W-1:0] & mask;
			res.hit = (lead == ent.code);
		end else begin
			// The code is longer: it may still match once more bits arrive.
			sh       = ent.len - nbits;
			tail     = ent.code >> sh;
			res.pend = ({{(BUF_BITS-CODE_W){1'b0}}, tail} == bits);
		end
	end

endmodule

`default_nettype wire
